### sv/wg1d_pkg.sv
// ----------------------------------------------------------------------------
// wg1d_pkg
// Types and constants for the one-dimensional Winograd tile transform:
// beat layouts, op and mode codes, and the rounding divisor tables.
// ----------------------------------------------------------------------------
package wg1d_pkg;

  localparam int LANES   = 8;
  localparam int XW      = 24;
  localparam int YW      = 40;
  localparam int VW      = 32;
  localparam int MW      = 31;
  localparam int RW      = 32;
  localparam int PW      = MW + RW;
  localparam int OW      = 6;

  localparam logic [1:0] OP_FILTER = 2'd0;
  localparam logic [1:0] OP_INPUT  = 2'd1;
  localparam logic [1:0] OP_OUTPUT = 2'd2;

  localparam logic MODE_F43 = 1'b0;
  localparam logic MODE_F45 = 1'b1;

  typedef struct packed {
    logic [1:0]             op;
    logic signed [XW-1:0]   x0;
    logic signed [XW-1:0]   x1;
    logic signed [XW-1:0]   x2;
    logic signed [XW-1:0]   x3;
    logic signed [XW-1:0]   x4;
    logic signed [XW-1:0]   x5;
    logic signed [XW-1:0]   x6;
    logic signed [XW-1:0]   x7;
  } in_item_t;

  typedef struct packed {
    logic signed [YW-1:0]   y0;
    logic signed [YW-1:0]   y1;
    logic signed [YW-1:0]   y2;
    logic signed [YW-1:0]   y3;
    logic signed [YW-1:0]   y4;
    logic signed [YW-1:0]   y5;
    logic signed [YW-1:0]   y6;
    logic signed [YW-1:0]   y7;
    logic [3:0]             valid_count;
  } out_item_t;

  // divisor d = 2^shift * odd, rounding adds d/2 before the floor divide
  localparam logic [LANES-1:0] RND_LANES [2] = '{8'b0001_1111, 8'b0111_1111};

  localparam logic [8:0] HALF [2][LANES] = '{
    '{9'd2,  9'd3,  9'd3,  9'd12, 9'd12, 9'd0,   9'd0,   9'd0},
    '{9'd18, 9'd24, 9'd24, 9'd60, 9'd60, 9'd360, 9'd360, 9'd0}
  };

  localparam logic [2:0] SHIFT [2][LANES] = '{
    '{3'd2, 3'd1, 3'd1, 3'd3, 3'd3, 3'd0, 3'd0, 3'd0},
    '{3'd2, 3'd4, 3'd4, 3'd3, 3'd3, 3'd4, 3'd4, 3'd0}
  };

  localparam logic [OW-1:0] ODD [2][LANES] = '{
    '{6'd1, 6'd3, 6'd3, 6'd3,  6'd3,  6'd1,  6'd1,  6'd1},
    '{6'd9, 6'd3, 6'd3, 6'd15, 6'd15, 6'd45, 6'd45, 6'd1}
  };

  // floor((2^32 - 1) / odd), estimate is low by at most one
  localparam logic [RW-1:0] R1  = 32'hFFFF_FFFF;
  localparam logic [RW-1:0] R3  = 32'd1431655765;
  localparam logic [RW-1:0] R9  = 32'd477218588;
  localparam logic [RW-1:0] R15 = 32'd286331153;
  localparam logic [RW-1:0] R45 = 32'd95443717;

  localparam logic [RW-1:0] RECIP [2][LANES] = '{
    '{R1, R3, R3, R3,  R3,  R1,  R1,  R1},
    '{R9, R3, R3, R15, R15, R45, R45, R1}
  };

endpackage

### sv/winograd_1d_tile_transform.sv
// ----------------------------------------------------------------------------
// winograd_1d_tile_transform
// Filter, input and output transforms of F(4,3) and F(4,5) in fixed point.
// ----------------------------------------------------------------------------
// an accepted input beat passes stage registers a, b, c and the output register to out_valid
// throughput: one beat per cycle while out_ready is high, set by the four register stages
// (combine, magnitude and bias, reciprocal multiply, correct and select)
// reset: rst clears all stage valid bits and sets kernel_mode to F(4,3)
module winograd_1d_tile_transform (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  wg1d_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wg1d_pkg::out_item_t  out_data
);
  import wg1d_pkg::*;

  logic kernel_mode;

  // stage a: linear combinations
  logic                 a_valid;
  logic signed [VW-1:0] a_val [LANES];
  logic [LANES-1:0]     a_rnd;
  logic                 a_mode;
  logic [3:0]           a_count;

  // stage b: biased magnitude, power of two removed
  logic                 b_valid;
  logic signed [VW-1:0] b_val [LANES];
  logic [MW-1:0]        b_mag [LANES];
  logic [LANES-1:0]     b_neg;
  logic [LANES-1:0]     b_rnd;
  logic                 b_mode;
  logic [3:0]           b_count;

  // stage c: reciprocal product
  logic                 c_valid;
  logic signed [VW-1:0] c_val [LANES];
  logic [MW-1:0]        c_mag [LANES];
  logic [PW-1:0]        c_prod [LANES];
  logic [LANES-1:0]     c_neg;
  logic [LANES-1:0]     c_rnd;
  logic                 c_mode;
  logic [3:0]           c_count;

  logic en_a, en_b, en_c, en_out;

  logic signed [VW-1:0] a_val_next [LANES];
  logic [LANES-1:0]     a_rnd_next;
  logic [3:0]           a_count_next;
  logic [MW-1:0]        b_mag_next [LANES];
  logic [LANES-1:0]     b_neg_next;
  out_item_t            out_next;

  assign en_out    = !out_valid || out_ready;
  assign en_c      = !c_valid || en_out;
  assign en_b      = !b_valid || en_c;
  assign en_a      = !a_valid || en_b;
  assign in_ready  = en_a;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_mode <= MODE_F43;
    end else if (cfg_valid) begin
      kernel_mode <= cfg_data;
    end
  end

  always_comb begin
    logic signed [VW-1:0] s [LANES];
    logic signed [VW-1:0] e, o;
    s[0] = VW'(in_data.x0);
    s[1] = VW'(in_data.x1);
    s[2] = VW'(in_data.x2);
    s[3] = VW'(in_data.x3);
    s[4] = VW'(in_data.x4);
    s[5] = VW'(in_data.x5);
    s[6] = VW'(in_data.x6);
    s[7] = VW'(in_data.x7);
    e = '0;
    o = '0;
    for (int i = 0; i < LANES; i++) begin
      a_val_next[i] = '0;
    end
    a_count_next = 4'd0;
    a_rnd_next   = '0;
    if (kernel_mode == MODE_F43) begin
      case (in_data.op)
        OP_FILTER: begin
          a_val_next[0] = s[0];
          a_val_next[1] = -(s[0] + s[1] + s[2]);
          a_val_next[2] = -(s[0] - s[1] + s[2]);
          a_val_next[3] = s[0] + (s[1] <<< 1) + (s[2] <<< 2);
          a_val_next[4] = s[0] - (s[1] <<< 1) + (s[2] <<< 2);
          a_val_next[5] = s[2];
          a_rnd_next    = RND_LANES[MODE_F43];
          a_count_next  = 4'd6;
        end
        OP_INPUT: begin
          a_val_next[0] = (s[0] <<< 2) - 32'sd5 * s[2] + s[4];
          a_val_next[1] = s[3] + s[4] - ((s[1] + s[2]) <<< 2);
          a_val_next[2] = ((s[1] - s[2]) <<< 2) + s[4] - s[3];
          a_val_next[3] = ((s[3] - s[1]) <<< 1) + s[4] - s[2];
          a_val_next[4] = ((s[1] - s[3]) <<< 1) + s[4] - s[2];
          a_val_next[5] = (s[1] <<< 2) - 32'sd5 * s[3] + s[5];
          a_count_next  = 4'd6;
        end
        OP_OUTPUT: begin
          a_val_next[0] = s[0] + s[1] + s[2] + s[3] + s[4];
          a_val_next[1] = s[1] - s[2] + ((s[3] - s[4]) <<< 1);
          a_val_next[2] = s[1] + s[2] + ((s[3] + s[4]) <<< 2);
          a_val_next[3] = s[1] - s[2] + ((s[3] - s[4]) <<< 3) + s[5];
          a_count_next  = 4'd4;
        end
        default: begin
          a_count_next = 4'd0;
        end
      endcase
    end else begin
      case (in_data.op)
        OP_FILTER: begin
          a_val_next[0] = s[0];
          e = s[0] + s[2] + s[4];
          o = s[1] + s[3];
          a_val_next[1] = e + o;
          a_val_next[2] = e - o;
          e = s[0] + (s[2] <<< 2) + (s[4] <<< 4);
          o = (s[1] <<< 1) + (s[3] <<< 3);
          a_val_next[3] = -(e + o);
          a_val_next[4] = -(e - o);
          e = s[0] + 32'sd9 * s[2] + 32'sd81 * s[4];
          o = 32'sd3 * s[1] + 32'sd27 * s[3];
          a_val_next[5] = e + o;
          a_val_next[6] = e - o;
          a_val_next[7] = s[4];
          a_rnd_next    = RND_LANES[MODE_F45];
          a_count_next  = 4'd8;
        end
        OP_INPUT: begin
          a_val_next[0] = 32'sd36 * s[0] - 32'sd49 * s[2] + 32'sd14 * s[4] - s[6];
          e = 32'sd36 * s[2] - 32'sd13 * s[4] + s[6];
          o = 32'sd36 * s[1] - 32'sd13 * s[3] + s[5];
          a_val_next[1] = e + o;
          a_val_next[2] = e - o;
          e = 32'sd9 * s[2] - 32'sd10 * s[4] + s[6];
          o = (32'sd9 * s[1] - 32'sd10 * s[3] + s[5]) <<< 1;
          a_val_next[3] = e + o;
          a_val_next[4] = e - o;
          e = (s[2] <<< 2) - 32'sd5 * s[4] + s[6];
          o = 32'sd3 * ((s[1] <<< 2) - 32'sd5 * s[3] + s[5]);
          a_val_next[5] = e + o;
          a_val_next[6] = e - o;
          a_val_next[7] = 32'sd49 * s[3] - 32'sd36 * s[1] + s[7] - 32'sd14 * s[5];
          a_count_next  = 4'd8;
        end
        OP_OUTPUT: begin
          a_val_next[0] = s[0] + s[1] + s[2] + s[3] + s[4] + s[5] + s[6];
          a_val_next[1] = s[1] - s[2] + ((s[3] - s[4]) <<< 1) + 32'sd3 * (s[5] - s[6]);
          a_val_next[2] = s[1] + s[2] + ((s[3] + s[4]) <<< 2) + 32'sd9 * (s[5] + s[6]);
          a_val_next[3] = s[7] + s[1] - s[2] + ((s[3] - s[4]) <<< 3)
                          + 32'sd27 * (s[5] - s[6]);
          a_count_next  = 4'd4;
        end
        default: begin
          a_count_next = 4'd0;
        end
      endcase
    end
  end

  always_comb begin
    logic [VW-1:0] mag;
    logic [MW-1:0] biased;
    for (int i = 0; i < LANES; i++) begin
      mag           = a_val[i][VW-1] ? VW'(-a_val[i]) : VW'(a_val[i]);
      biased        = mag[MW-1:0] + MW'(HALF[a_mode][i]);
      b_mag_next[i] = biased >> SHIFT[a_mode][i];
      b_neg_next[i] = a_val[i][VW-1];
    end
  end

  always_comb begin
    logic [MW-1:0]      q_est;
    logic [MW+OW-1:0]   back;
    logic [MW-1:0]      rem;
    logic [MW-1:0]      q;
    logic signed [YW-1:0] y [LANES];
    for (int i = 0; i < LANES; i++) begin
      q_est = c_prod[i][PW-1:RW];
      back  = q_est * ODD[c_mode][i];
      rem   = c_mag[i] - back[MW-1:0];
      q     = q_est + MW'(rem >= MW'(ODD[c_mode][i]));
      if (c_rnd[i]) begin
        y[i] = c_neg[i] ? -$signed({{(YW-MW){1'b0}}, q}) : $signed({{(YW-MW){1'b0}}, q});
      end else begin
        y[i] = YW'(c_val[i]);
      end
    end
    out_next.y0          = y[0];
    out_next.y1          = y[1];
    out_next.y2          = y[2];
    out_next.y3          = y[3];
    out_next.y4          = y[4];
    out_next.y5          = y[5];
    out_next.y6          = y[6];
    out_next.y7          = y[7];
    out_next.valid_count = c_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_a) a_valid <= in_valid;
      if (en_b) b_valid <= a_valid;
      if (en_c) c_valid <= b_valid;
      if (en_out) out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_valid) begin
      a_val   <= a_val_next;
      a_rnd   <= a_rnd_next;
      a_mode  <= kernel_mode;
      a_count <= a_count_next;
    end
    if (en_b && a_valid) begin
      b_val   <= a_val;
      b_mag   <= b_mag_next;
      b_neg   <= b_neg_next;
      b_rnd   <= a_rnd;
      b_mode  <= a_mode;
      b_count <= a_count;
    end
    if (en_c && b_valid) begin
      for (int i = 0; i < LANES; i++) begin
        c_prod[i] <= b_mag[i] * RECIP[b_mode][i];
      end
      c_val   <= b_val;
      c_mag   <= b_mag;
      c_neg   <= b_neg;
      c_rnd   <= b_rnd;
      c_mode  <= b_mode;
      c_count <= b_count;
    end
    if (en_out && c_valid) begin
      out_data <= out_next;
    end
  end

endmodule

### tb/wg1d_transform_checker.sv
// ----------------------------------------------------------------------------
// wg1d_transform_checker
// Watches the config, input and result channels of the Winograd tile
// transform, computes the expected result of every accepted input beat from
// its own copy of the kernel mode, and compares result beats in order.
// ----------------------------------------------------------------------------
module wg1d_transform_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic                 cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  wg1d_pkg::in_item_t   in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  wg1d_pkg::out_item_t  out_data,
  output int                   mismatches,
  output int                   pending
);
  import wg1d_pkg::*;

  logic      kernel_mode;
  out_item_t expected_tiles[$];

  // round to nearest, ties away from zero
  function automatic longint round_div(input longint n, input longint d);
    longint m;
    longint q;
    m = (n < 0) ? -n : n;
    q = (2 * m + d) / (2 * d);
    return (n < 0) ? -q : q;
  endfunction

  function automatic out_item_t transform_tile(input in_item_t t, input logic m);
    longint    s[LANES];
    longint    y[LANES];
    longint    e;
    longint    o;
    longint    a1, d1, a2, d2, a3, d3;
    logic [3:0] count;
    out_item_t r;
    s = '{t.x0, t.x1, t.x2, t.x3, t.x4, t.x5, t.x6, t.x7};
    y = '{default: 0};
    count = 4'd0;
    if (m == MODE_F43) begin
      case (t.op)
        OP_FILTER: begin
          y[0] = round_div(s[0], 4);
          y[1] = round_div(-(s[0] + s[1] + s[2]), 6);
          y[2] = round_div(-(s[0] - s[1] + s[2]), 6);
          y[3] = round_div(s[0] + 2 * s[1] + 4 * s[2], 24);
          y[4] = round_div(s[0] - 2 * s[1] + 4 * s[2], 24);
          y[5] = s[2];
          count = 4'd6;
        end
        OP_INPUT: begin
          y[0] = 4 * s[0] - 5 * s[2] + s[4];
          y[1] = s[3] + s[4] - 4 * (s[1] + s[2]);
          y[2] = 4 * (s[1] - s[2]) + s[4] - s[3];
          y[3] = 2 * (s[3] - s[1]) + s[4] - s[2];
          y[4] = 2 * (s[1] - s[3]) + s[4] - s[2];
          y[5] = 4 * s[1] - 5 * s[3] + s[5];
          count = 4'd6;
        end
        OP_OUTPUT: begin
          y[0] = s[0] + s[1] + s[2] + s[3] + s[4];
          y[1] = s[1] - s[2] + 2 * (s[3] - s[4]);
          y[2] = s[1] + s[2] + 4 * (s[3] + s[4]);
          y[3] = s[1] - s[2] + 8 * (s[3] - s[4]) + s[5];
          count = 4'd4;
        end
        default: count = 4'd0;
      endcase
    end else begin
      case (t.op)
        OP_FILTER: begin
          y[0] = round_div(s[0], 36);
          e = s[0] + s[2] + s[4];
          o = s[1] + s[3];
          y[1] = round_div(e + o, 48);
          y[2] = round_div(e - o, 48);
          e = s[0] + 4 * s[2] + 16 * s[4];
          o = 2 * s[1] + 8 * s[3];
          y[3] = round_div(-(e + o), 120);
          y[4] = round_div(-(e - o), 120);
          e = s[0] + 9 * s[2] + 81 * s[4];
          o = 3 * s[1] + 27 * s[3];
          y[5] = round_div(e + o, 720);
          y[6] = round_div(e - o, 720);
          y[7] = s[4];
          count = 4'd8;
        end
        OP_INPUT: begin
          y[0] = 36 * s[0] - 49 * s[2] + 14 * s[4] - s[6];
          e = 36 * s[2] - 13 * s[4] + s[6];
          o = 36 * s[1] - 13 * s[3] + s[5];
          y[1] = e + o;
          y[2] = e - o;
          e = 9 * s[2] - 10 * s[4] + s[6];
          o = 2 * (9 * s[1] - 10 * s[3] + s[5]);
          y[3] = e + o;
          y[4] = e - o;
          e = 4 * s[2] - 5 * s[4] + s[6];
          o = 3 * (4 * s[1] - 5 * s[3] + s[5]);
          y[5] = e + o;
          y[6] = e - o;
          y[7] = 49 * s[3] - 36 * s[1] + s[7] - 14 * s[5];
          count = 4'd8;
        end
        OP_OUTPUT: begin
          a1 = s[1] + s[2];
          d1 = s[1] - s[2];
          a2 = s[3] + s[4];
          d2 = 2 * (s[3] - s[4]);
          a3 = s[5] + s[6];
          d3 = 3 * (s[5] - s[6]);
          y[0] = s[0] + a1 + a2 + a3;
          y[1] = d1 + d2 + d3;
          y[2] = a1 + 4 * a2 + 9 * a3;
          y[3] = s[7] + d1 + 4 * d2 + 9 * d3;
          count = 4'd4;
        end
        default: count = 4'd0;
      endcase
    end
    r = '0;
    for (int i = 0; i < LANES; i++) begin
      r[YW * (LANES - i) + 3 -: YW] = y[i][YW-1:0];
    end
    r.valid_count = count;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    logic signed [YW-1:0] w;
    logic signed [YW-1:0] g;
    if (rst) begin
      kernel_mode <= MODE_F43;
      expected_tiles.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_tiles.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with nothing expected, got %h", $time, out_data);
        end else begin
          want = expected_tiles.pop_front();
          for (int i = 0; i < LANES; i++) begin
            w = want[YW * (LANES - i) + 3 -: YW];
            g = out_data[YW * (LANES - i) + 3 -: YW];
            if (w !== g) begin
              mismatches++;
              $display("%0t: y%0d expected %0d got %0d", $time, i, w, g);
            end
          end
          if (want.valid_count !== out_data.valid_count) begin
            mismatches++;
            $display("%0t: valid_count expected %0d got %0d", $time,
                     want.valid_count, out_data.valid_count);
          end
        end
      end
      if (in_valid && in_ready)
        expected_tiles.push_back(transform_tile(in_data, kernel_mode));
      if (cfg_valid && cfg_ready)
        kernel_mode <= cfg_data;
    end
    pending = expected_tiles.size();
  end

endmodule

### tb/winograd_1d_tile_transform_test.sv
// ----------------------------------------------------------------------------
// winograd_1d_tile_transform_test
// Drives the tile transform with directed corner beats and random tiles in
// both kernel modes, with random idle bursts on the input and result sides,
// and reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module winograd_1d_tile_transform_test;
  import wg1d_pkg::*;

  localparam logic [1:0]          OP_BAD = 2'd3;
  localparam logic signed [XW-1:0] XMAX  = 24'h7F_FFFF;
  localparam logic signed [XW-1:0] XMIN  = 24'h80_0000;
  localparam logic [1:0]          OPS [3] = '{OP_FILTER, OP_INPUT, OP_OUTPUT};

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = MODE_F43;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b1;
  out_item_t out_data;

  int   mismatches;
  int   pending;
  logic calm = 1'b0;
  int   stall_left = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  winograd_1d_tile_transform DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  wg1d_transform_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // result side back-pressure in bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic in_item_t patterned_tile(input logic [1:0] op,
                                              input logic signed [XW-1:0] lead,
                                              input logic signed [XW-1:0] even_v,
                                              input logic signed [XW-1:0] odd_v);
    in_item_t t;
    t.op = op;
    t.x0 = lead;
    t.x1 = odd_v;
    t.x2 = even_v;
    t.x3 = odd_v;
    t.x4 = even_v;
    t.x5 = odd_v;
    t.x6 = even_v;
    t.x7 = odd_v;
    return t;
  endfunction

  function automatic logic signed [XW-1:0] random_sample();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 3))
          0: return XMAX;
          1: return XMIN;
          2: return '0;
          default: return '1;
        endcase
      end
      1: return XW'(int'($urandom_range(0, 255)) - 128);
      default: return XW'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_tile();
    in_item_t t;
    t.op = ($urandom_range(0, 99) < 3) ? OP_BAD : 2'($urandom_range(0, 2));
    t.x0 = random_sample();
    t.x1 = random_sample();
    t.x2 = random_sample();
    t.x3 = random_sample();
    t.x4 = random_sample();
    t.x5 = random_sample();
    t.x6 = random_sample();
    t.x7 = random_sample();
    return t;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_tile(input in_item_t t);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic run_directed(input logic m);
    for (int i = 0; i < 3; i++) begin
      send_tile(patterned_tile(OPS[i], XMAX, XMAX, XMAX));
      send_tile(patterned_tile(OPS[i], XMIN, XMIN, XMIN));
    end
    send_tile(patterned_tile(OP_INPUT, XMAX, XMAX, XMIN));
    send_tile(patterned_tile(OP_OUTPUT, XMIN, XMIN, XMAX));
    send_tile(patterned_tile(OP_BAD, XMAX, XMAX, XMAX));
    // rounding ties in the filter scalings
    if (m == MODE_F43) begin
      send_tile(patterned_tile(OP_FILTER, 24'sd3, '0, '0));
      send_tile(patterned_tile(OP_FILTER, -24'sd6, '0, '0));
      send_tile(patterned_tile(OP_FILTER, 24'sd12, '0, '0));
    end else begin
      send_tile(patterned_tile(OP_FILTER, 24'sd18, '0, '0));
      send_tile(patterned_tile(OP_FILTER, -24'sd24, '0, '0));
      send_tile(patterned_tile(OP_FILTER, 24'sd60, '0, '0));
      send_tile(patterned_tile(OP_FILTER, -24'sd360, '0, '0));
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_mode(MODE_F43);
    run_directed(MODE_F43);
    drain();
    write_mode(MODE_F45);
    run_directed(MODE_F45);
    drain();
    for (int p = 0; p < 6; p++) begin
      calm = (p == 5);
      write_mode((p % 2 == 0) ? MODE_F43 : MODE_F45);
      repeat (325) send_tile(random_tile());
      drain();
    end
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
